/* hw/rtl/lfo_pkg.sv */
// lfo_pkg: shared types, constants and the quarter-sine table function for
// the multi-waveform LFO. No dependencies; used by every file in hw/rtl except lfo_checker.

package lfo_pkg;

    // Default parameter values
    localparam int SINE_DEPTH_DEF = 1024;
    localparam int MAX_RUN_DEF    = 64;
    localparam int PHASE_BITS_DEF = 32;

    // Register indexes on the config port
    localparam logic [2:0] REG_ENABLE       = 3'd0;
    localparam logic [2:0] REG_WAVE_SELECT  = 3'd1;
    localparam logic [2:0] REG_PHASE_STEP   = 3'd2;
    localparam logic [2:0] REG_PHASE_OFFSET = 3'd3;
    localparam logic [2:0] REG_PULSE_WIDTH  = 3'd4;
    localparam logic [2:0] REG_DEPTH        = 3'd5;
    localparam logic [2:0] REG_HOLD_PERIOD  = 3'd6;

    // Waveform codes
    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
    localparam logic [2:0] WAVE_SAW      = 3'd2;
    localparam logic [2:0] WAVE_INV_SAW  = 3'd3;
    localparam logic [2:0] WAVE_SQUARE   = 3'd4;
    localparam logic [2:0] WAVE_PULSE    = 3'd5;
    localparam logic [2:0] WAVE_NOISE    = 3'd6;
    localparam logic [2:0] WAVE_HOLD     = 3'd7;

    // Register reset values
    localparam logic        RST_ENABLE       = 1'b1;
    localparam logic [2:0]  RST_WAVE_SELECT  = WAVE_SINE;
    localparam logic [31:0] RST_PHASE_STEP   = 32'd0;
    localparam logic [31:0] RST_PHASE_OFFSET = 32'd0;
    localparam logic [16:0] RST_PULSE_WIDTH  = 17'd32768;
    localparam logic [16:0] RST_DEPTH        = 17'd65536;
    localparam logic [23:0] RST_HOLD_PERIOD  = 24'd0;

    // LCG and smoothing constants
    localparam logic [31:0] LCG_ADD    = 32'd1013904223;
    localparam logic [31:0] NOISE_SEED = 32'd12345;
    localparam logic [31:0] HOLD_SEED  = 32'd67890;

    // Shared multiplier operand widths (signed)
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 22;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic signed [MUL_B_W-1:0] LCG_MUL    = 22'sd1664525;
    localparam logic signed [MUL_B_W-1:0] NOISE_KEEP = 22'sd3277;   // 0.1 in Q15
    localparam logic signed [MUL_B_W-1:0] NOISE_NEW  = 22'sd29491;  // 0.9 in Q15

    // pi/2 in Q28
    localparam logic [63:0] HALF_PI_Q28 = 64'd421657428;

    typedef struct packed {
        logic        enable;
        logic [2:0]  wave_select;
        logic [31:0] phase_step;
        logic [31:0] phase_offset;
        logic [16:0] pulse_width;
        logic [16:0] depth;
        logic [23:0] hold_period;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SINE_ADDR,
        S_SINE_VAL,
        S_NOISE_LCG,
        S_NOISE_A,
        S_NOISE_B,
        S_HOLD_LCG,
        S_SCALE,
        S_ROUND,
        S_OUT
    } state_t;

    // Quarter-sine entry from a Q28 angle: Taylor series to x^13, rounded to Q15.
    // Evaluated at elaboration only.
    function automatic logic [15:0] sine_entry(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        x2   = (x * x) >> 28;
        term = x;
        acc  = $signed(x);
        term = ((term * x2) >> 28) / 64'd6;
        acc  = acc - $signed(term);
        term = ((term * x2) >> 28) / 64'd20;
        acc  = acc + $signed(term);
        term = ((term * x2) >> 28) / 64'd42;
        acc  = acc - $signed(term);
        term = ((term * x2) >> 28) / 64'd72;
        acc  = acc + $signed(term);
        term = ((term * x2) >> 28) / 64'd110;
        acc  = acc - $signed(term);
        term = ((term * x2) >> 28) / 64'd156;
        acc  = acc + $signed(term);
        if (acc < 0)
        begin
            acc = 64'sd0;
        end
        acc = (acc + 64'sd4096) >>> 13;
        if (acc > 64'sd32768)
        begin
            acc = 64'sd32768;
        end
        return acc[15:0];
    endfunction

endpackage

/* hw/rtl/lfo_mul.sv */
// lfo_mul: the one shared signed multiplier of the LFO, product registered.
// Depends on lfo_pkg for operand widths.

module lfo_mul (
    input  logic                                clk,
    input  logic signed [lfo_pkg::MUL_A_W-1:0]  a,
    input  logic signed [lfo_pkg::MUL_B_W-1:0]  b,
    output logic signed [lfo_pkg::MUL_P_W-1:0]  p
);

    logic signed [lfo_pkg::MUL_P_W-1:0] prod_reg;
    logic signed [lfo_pkg::MUL_P_W-1:0] prod_next;

    assign prod_next = lfo_pkg::MUL_P_W'(a) * lfo_pkg::MUL_P_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign p = prod_reg;

endmodule

/* hw/rtl/lfo_sine_rom.sv */
// lfo_sine_rom: quarter-wave sine ROM (SINE_TABLE_DEPTH+1 entries, Q15),
// registered read. Entries come from lfo_pkg::sine_entry at elaboration.

module lfo_sine_rom #(
    parameter int SINE_TABLE_DEPTH = lfo_pkg::SINE_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]  addr,
    output logic [15:0]                            data
);

    logic [15:0] rom [0:SINE_TABLE_DEPTH];
    logic [15:0] data_reg;

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++)
    begin : g_entry
        localparam logic [63:0] X =
            (64'(k) * lfo_pkg::HALF_PI_Q28) / 64'(SINE_TABLE_DEPTH);
        assign rom[k] = lfo_pkg::sine_entry(X);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom[addr];
    end

    assign data = data_reg;

endmodule

/* hw/rtl/lfo_seq.sv */
// lfo_seq: per-sample sequencer of the LFO: phase, noise and hold state,
// waveform selection, and the operand schedule of the shared multiplier.
// Depends on lfo_pkg; drives lfo_mul and lfo_sine_rom from the top level.

module lfo_seq #(
    parameter int SINE_TABLE_DEPTH = lfo_pkg::SINE_DEPTH_DEF,
    parameter int MAX_RUN          = lfo_pkg::MAX_RUN_DEF,
    parameter int PHASE_BITS       = lfo_pkg::PHASE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lfo_pkg::cfg_t                          cfg,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   in_restart,
    input  logic [6:0]                             in_count,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [15:0]                            out_sample,
    output logic                                   out_active,
    output logic                                   out_last,
    output logic signed [lfo_pkg::MUL_A_W-1:0]     mul_a,
    output logic signed [lfo_pkg::MUL_B_W-1:0]     mul_b,
    input  logic signed [lfo_pkg::MUL_P_W-1:0]     mul_p,
    output logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]  rom_addr,
    input  logic [15:0]                            rom_data
);

    localparam int PAD   = 32 - PHASE_BITS;
    localparam int CNT_W = $clog2(MAX_RUN + 1);
    localparam int POS_W = $clog2(4 * SINE_TABLE_DEPTH);
    localparam int AW    = $clog2(SINE_TABLE_DEPTH + 1);

    localparam logic [POS_W-1:0] Q1_BASE = POS_W'(SINE_TABLE_DEPTH);
    localparam logic [POS_W-1:0] Q2_BASE = POS_W'(2 * SINE_TABLE_DEPTH);
    localparam logic [POS_W-1:0] Q3_BASE = POS_W'(3 * SINE_TABLE_DEPTH);
    localparam logic [AW-1:0]    ROM_TOP = AW'(SINE_TABLE_DEPTH);
    localparam logic signed [lfo_pkg::MUL_B_W-1:0] SINE_SCALE =
        lfo_pkg::MUL_B_W'(4 * SINE_TABLE_DEPTH);

    localparam logic signed [16:0] VAL_POS = 17'sd32768;
    localparam logic signed [16:0] VAL_NEG = -17'sd32768;

    lfo_pkg::state_t state_reg, state_next;

    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [14:0]           noise_level_reg, noise_level_next;
    logic [31:0]           noise_lcg_reg, noise_lcg_next;
    logic [15:0]           held_reg, held_next;
    logic [23:0]           hold_count_reg, hold_count_next;
    logic [31:0]           hold_lcg_reg, hold_lcg_next;
    logic [CNT_W-1:0]      left_reg, left_next;

    logic signed [16:0]    value_reg, value_next;
    logic [26:0]           mix_reg, mix_next;
    logic                  neg_reg, neg_next;
    logic [15:0]           sample_reg, sample_next;
    logic                  active_reg, active_next;

    logic [31:0]           p;
    logic [16:0]           pw_cl;
    logic [16:0]           depth_cl;
    logic [6:0]            run_len;
    logic signed [17:0]    tri_v;
    logic signed [17:0]    saw_v;
    logic signed [17:0]    inv_v;
    logic [POS_W-1:0]      pos;
    logic [1:0]            quad;
    logic [POS_W-1:0]      k_pos;
    logic [31:0]           lcg_new;
    logic [29:0]           nsum;
    logic [14:0]           lvl;
    logic signed [33:0]    rnd;
    logic signed [17:0]    scl;

    // Full 32-bit phase; low bits below PHASE_BITS are zero
    assign p        = 32'(phase_reg) << PAD;
    assign pw_cl    = cfg.pulse_width[16] ? 17'h10000 : cfg.pulse_width;
    assign depth_cl = cfg.depth[16] ? 17'h10000 : cfg.depth;
    assign run_len  = (in_count > 7'(MAX_RUN)) ? 7'(MAX_RUN) : in_count;

    assign tri_v = p[31] ? (18'sd98304 - $signed({1'b0, p[31:15]}))
                         : ($signed({1'b0, p[31:15]}) - 18'sd32768);
    assign saw_v = $signed({2'b00, p[31:16]}) - 18'sd32768;
    assign inv_v = 18'sd32768 - $signed({2'b00, p[31:16]});

    // Sine table position: (p * 4 * depth) >> 32, split into quadrant and index
    assign pos = mul_p[32 +: POS_W];
    always_comb
    begin
        if (pos >= Q3_BASE)
        begin
            quad  = 2'd3;
            k_pos = pos - Q3_BASE;
        end
        else if (pos >= Q2_BASE)
        begin
            quad  = 2'd2;
            k_pos = pos - Q2_BASE;
        end
        else if (pos >= Q1_BASE)
        begin
            quad  = 2'd1;
            k_pos = pos - Q1_BASE;
        end
        else
        begin
            quad  = 2'd0;
            k_pos = pos;
        end
    end
    assign rom_addr = quad[0] ? (ROM_TOP - AW'(k_pos)) : AW'(k_pos);

    assign lcg_new = mul_p[31:0] + lfo_pkg::LCG_ADD;
    assign nsum    = 30'(mix_reg) + mul_p[29:0] + 30'd16384;
    assign lvl     = nsum[29:15];

    // floor((v*depth + 32768) / 65536)
    assign rnd = $signed(mul_p[33:0]) + 34'sd32768;
    assign scl = rnd[33:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lfo_pkg::S_IDLE;
            phase_reg       <= '0;
            noise_level_reg <= '0;
            noise_lcg_reg   <= lfo_pkg::NOISE_SEED;
            held_reg        <= '0;
            hold_count_reg  <= '0;
            hold_lcg_reg    <= lfo_pkg::HOLD_SEED;
            left_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            noise_level_reg <= noise_level_next;
            noise_lcg_reg   <= noise_lcg_next;
            held_reg        <= held_next;
            hold_count_reg  <= hold_count_next;
            hold_lcg_reg    <= hold_lcg_next;
            left_reg        <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        mix_reg    <= mix_next;
        neg_reg    <= neg_next;
        sample_reg <= sample_next;
        active_reg <= active_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        noise_level_next = noise_level_reg;
        noise_lcg_next   = noise_lcg_reg;
        held_next        = held_reg;
        hold_count_next  = hold_count_reg;
        hold_lcg_next    = hold_lcg_reg;
        left_next        = left_reg;
        value_next       = value_reg;
        mix_next         = mix_reg;
        neg_next         = neg_reg;
        sample_next      = sample_reg;
        active_next      = active_reg;
        mul_a            = '0;
        mul_b            = '0;
        in_ready         = 1'b0;
        out_valid        = 1'b0;

        case (state_reg)
            lfo_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_restart)
                    begin
                        phase_next       = cfg.phase_offset[31 -: PHASE_BITS];
                        noise_level_next = '0;
                        held_next        = '0;
                        hold_count_next  = '0;
                    end
                    left_next = CNT_W'(run_len);
                    if (run_len != 7'd0)
                    begin
                        state_next = lfo_pkg::S_START;
                    end
                end
            end

            lfo_pkg::S_START:
            begin
                active_next = cfg.enable;
                if (!cfg.enable)
                begin
                    sample_next = '0;
                    state_next  = lfo_pkg::S_OUT;
                end
                else
                begin
                    state_next = lfo_pkg::S_SCALE;
                    case (cfg.wave_select)
                        lfo_pkg::WAVE_SINE:
                        begin
                            mul_a      = $signed({1'b0, p});
                            mul_b      = SINE_SCALE;
                            state_next = lfo_pkg::S_SINE_ADDR;
                        end
                        lfo_pkg::WAVE_TRIANGLE: value_next = 17'(tri_v);
                        lfo_pkg::WAVE_SAW:      value_next = 17'(saw_v);
                        lfo_pkg::WAVE_INV_SAW:  value_next = 17'(inv_v);
                        lfo_pkg::WAVE_SQUARE:   value_next = p[31] ? VAL_POS : VAL_NEG;
                        lfo_pkg::WAVE_PULSE:
                        begin
                            value_next = ({1'b0, p} < {pw_cl, 16'h0000}) ? VAL_NEG
                                                                         : VAL_POS;
                        end
                        lfo_pkg::WAVE_NOISE:
                        begin
                            mul_a      = $signed({1'b0, noise_lcg_reg});
                            mul_b      = lfo_pkg::LCG_MUL;
                            state_next = lfo_pkg::S_NOISE_LCG;
                        end
                        default:
                        begin
                            if (hold_count_reg >= cfg.hold_period)
                            begin
                                hold_count_next = '0;
                                mul_a           = $signed({1'b0, hold_lcg_reg});
                                mul_b           = lfo_pkg::LCG_MUL;
                                state_next      = lfo_pkg::S_HOLD_LCG;
                            end
                            else
                            begin
                                hold_count_next = hold_count_reg + 24'd1;
                                value_next      = $signed({held_reg[15], held_reg});
                            end
                        end
                    endcase
                end
            end

            lfo_pkg::S_SINE_ADDR:
            begin
                neg_next   = quad[1];
                state_next = lfo_pkg::S_SINE_VAL;
            end

            lfo_pkg::S_SINE_VAL:
            begin
                value_next = neg_reg ? -$signed({1'b0, rom_data})
                                     : $signed({1'b0, rom_data});
                state_next = lfo_pkg::S_SCALE;
            end

            lfo_pkg::S_NOISE_LCG:
            begin
                noise_lcg_next = lcg_new;
                mul_a          = $signed(33'(noise_level_reg));
                mul_b          = lfo_pkg::NOISE_KEEP;
                state_next     = lfo_pkg::S_NOISE_A;
            end

            lfo_pkg::S_NOISE_A:
            begin
                mix_next   = mul_p[26:0];
                mul_a      = $signed(33'(noise_lcg_reg[30:16]));
                mul_b      = lfo_pkg::NOISE_NEW;
                state_next = lfo_pkg::S_NOISE_B;
            end

            lfo_pkg::S_NOISE_B:
            begin
                noise_level_next = lvl;
                // 2*level - 32768 in 16 bits is the level doubled with the top bit flipped
                value_next = $signed({~lvl[14], ~lvl[14], lvl[13:0], 1'b0});
                state_next = lfo_pkg::S_SCALE;
            end

            lfo_pkg::S_HOLD_LCG:
            begin
                hold_lcg_next = lcg_new;
                held_next     = {~lcg_new[30], lcg_new[29:16], 1'b0};
                value_next    = $signed({~lcg_new[30], ~lcg_new[30], lcg_new[29:16], 1'b0});
                state_next    = lfo_pkg::S_SCALE;
            end

            lfo_pkg::S_SCALE:
            begin
                mul_a      = $signed({{16{value_reg[16]}}, value_reg});
                mul_b      = $signed({5'b00000, depth_cl});
                state_next = lfo_pkg::S_ROUND;
            end

            lfo_pkg::S_ROUND:
            begin
                if (scl > 18'sd32767)
                begin
                    sample_next = 16'h7FFF;
                end
                else if (scl < -18'sd32768)
                begin
                    sample_next = 16'h8000;
                end
                else
                begin
                    sample_next = scl[15:0];
                end
                phase_next = phase_reg + cfg.phase_step[31 -: PHASE_BITS];
                state_next = lfo_pkg::S_OUT;
            end

            lfo_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    left_next  = left_reg - CNT_W'(1);
                    state_next = (left_reg == CNT_W'(1)) ? lfo_pkg::S_IDLE
                                                         : lfo_pkg::S_START;
                end
            end

            default:
            begin
                state_next = lfo_pkg::S_IDLE;
            end
        endcase
    end

    assign out_sample = sample_reg;
    assign out_active = active_reg;
    assign out_last   = (left_reg == CNT_W'(1));

endmodule

/* hw/rtl/lfo_multi_waveform.sv */
// lfo_multi_waveform: request in, 0..MAX_RUN samples out, one shared multiplier.
// A request is taken in the idle state; a count of zero makes no samples. Each
// sample runs through the sequencer states of its waveform (sine reads the ROM,
// noise draws from its LCG, hold may draw; disabled gives zero) and waits on the
// output until taken. One request at a time; per-sample cost follows the shared
// multiplier schedule. Reset (rst_n, async): registers to defaults, LCGs seeded.

module lfo_multi_waveform #(
    parameter int SINE_TABLE_DEPTH = lfo_pkg::SINE_DEPTH_DEF,
    parameter int MAX_RUN          = lfo_pkg::MAX_RUN_DEF,
    parameter int PHASE_BITS       = lfo_pkg::PHASE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [0] restart, [7:1] sample_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [15:0] sample
    output logic        m_tuser,     // [0] active
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);

    lfo_pkg::cfg_t cfg_reg, cfg_next;

    logic signed [lfo_pkg::MUL_A_W-1:0] mul_a;
    logic signed [lfo_pkg::MUL_B_W-1:0] mul_b;
    logic signed [lfo_pkg::MUL_P_W-1:0] mul_p;
    logic [AW-1:0]                      rom_addr;
    logic [15:0]                        rom_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                lfo_pkg::REG_ENABLE:       cfg_next.enable       = cfg_data[0];
                lfo_pkg::REG_WAVE_SELECT:  cfg_next.wave_select  = cfg_data[2:0];
                lfo_pkg::REG_PHASE_STEP:   cfg_next.phase_step   = cfg_data;
                lfo_pkg::REG_PHASE_OFFSET: cfg_next.phase_offset = cfg_data;
                lfo_pkg::REG_PULSE_WIDTH:  cfg_next.pulse_width  = cfg_data[16:0];
                lfo_pkg::REG_DEPTH:        cfg_next.depth        = cfg_data[16:0];
                lfo_pkg::REG_HOLD_PERIOD:  cfg_next.hold_period  = cfg_data[23:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable       <= lfo_pkg::RST_ENABLE;
            cfg_reg.wave_select  <= lfo_pkg::RST_WAVE_SELECT;
            cfg_reg.phase_step   <= lfo_pkg::RST_PHASE_STEP;
            cfg_reg.phase_offset <= lfo_pkg::RST_PHASE_OFFSET;
            cfg_reg.pulse_width  <= lfo_pkg::RST_PULSE_WIDTH;
            cfg_reg.depth        <= lfo_pkg::RST_DEPTH;
            cfg_reg.hold_period  <= lfo_pkg::RST_HOLD_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lfo_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    lfo_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    lfo_seq #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .MAX_RUN          (MAX_RUN),
        .PHASE_BITS       (PHASE_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_restart (s_tdata[0]),
        .in_count   (s_tdata[7:1]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (m_tdata),
        .out_active (m_tuser),
        .out_last   (m_tlast),
        .mul_a      (mul_a),
        .mul_b      (mul_b),
        .mul_p      (mul_p),
        .rom_addr   (rom_addr),
        .rom_data   (rom_data)
    );

endmodule

/* hw/rtl/lfo_checker.sv */
// lfo_checker: port-level checks for lfo_multi_waveform, bound to the top.
// Depends only on the top level's ports.

module lfo_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // no new request is taken while a word is on offer
    a_busy_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("request side ready while a word is pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("output word changed while stalled");

    // disabled samples are zero
    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 16'h0000)
        else $error("inactive word carries a nonzero sample");

    // an empty request makes no words
    a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[7:1] == 7'd0 |=> s_tready && !m_tvalid)
        else $error("empty request did not return to idle");

    // after the last word of a run the block is idle again
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("not idle after last word");

endmodule

bind lfo_multi_waveform lfo_checker u_lfo_checker (.*);
